### sv/gle_pkg.sv
// ----------------------------------------------------------------------------
// gle_pkg
// Shared constants, types and helpers for the LZW encoder core.
// ----------------------------------------------------------------------------
package gle_pkg;

    localparam int DICT_SLOTS_DEF    = 8192;
    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int KEY_W             = 20;
    localparam int CODE_W            = 12;
    localparam int ENTRY_W           = KEY_W + CODE_W;

    localparam logic [0:0] REG_CODE_SIZE  = 1'd0;
    localparam logic [0:0] REG_DICT_LIMIT = 1'd1;

    // packer request: one code of up to 12 bits, optional flush
    typedef struct packed {
        logic [11:0] code;
        logic [3:0]  width;
        logic        flush;
    } gle_code_t;

    function automatic logic [31:0] gle_hash(input logic [KEY_W-1:0] key);
        logic [31:0] p;
        p = 32'({12'd0, key}) * 32'd2654435761;
        return p >> 7;
    endfunction

endpackage

### sv/gle_ram.sv
// ----------------------------------------------------------------------------
// gle_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module gle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### sv/gle_packer.sv
// ----------------------------------------------------------------------------
// gle_packer
// Bit packer: takes one code at a time, emits bytes LSB first on a stream.
// ----------------------------------------------------------------------------
module gle_packer
    import gle_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       code_valid,
    output logic       code_ready,
    input  gle_code_t  code_req,
    output logic       busy,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic       m_axis_tuser
);
    logic [19:0] acc_reg, acc_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        flush_reg, flush_next;
    logic        ov_reg, ov_next;
    logic [7:0]  ob_reg, ob_next;
    logic        ol_reg, ol_next;
    logic        emit;
    logic [11:0] mask;

    assign code_ready = (cnt_reg < 5'd8) && !flush_reg;
    assign busy = (cnt_reg != 5'd0) || flush_reg || ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = ob_reg;
    assign m_axis_tuser  = ol_reg;
    assign mask = 12'((13'd1 << code_req.width) - 13'd1);

    always_comb begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        flush_next = flush_reg;
        ov_next = ov_reg && !m_axis_tready;
        ob_next = ob_reg;
        ol_next = ol_reg;
        emit = !ov_reg || m_axis_tready;
        if (emit && (cnt_reg >= 5'd8 || (flush_reg && cnt_reg != 5'd0))) begin
            ov_next = 1'b1;
            ob_next = acc_reg[7:0];
            ol_next = flush_reg && cnt_reg <= 5'd8;
            acc_next = acc_reg >> 8;
            cnt_next = (cnt_reg >= 5'd8) ? cnt_reg - 5'd8 : 5'd0;
            if (ol_next) begin
                flush_next = 1'b0;
                cnt_next = 5'd0;
                acc_next = '0;
            end
        end
        if (code_valid && code_ready) begin
            acc_next = acc_next | (20'(code_req.code & mask) << cnt_next);
            cnt_next = cnt_next + 5'(code_req.width);
            flush_next = code_req.flush;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            cnt_reg <= '0;
            flush_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            flush_reg <= flush_next;
            ov_reg <= ov_next;
        end
        ob_reg <= ob_next;
        ol_reg <= ol_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        code_valid && code_ready |-> cnt_reg < 5'd8)
        else $error("code taken with full byte pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 5'd19)
        else $error("accumulator overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ov_reg && !m_axis_tready |=> $stable(ob_reg))
        else $error("output byte changed under stall");
endmodule

### sv/gle_ctrl.sv
// ----------------------------------------------------------------------------
// gle_ctrl
// LZW sequencer: hashed dictionary probe, code emission, clearing sweep.
// ----------------------------------------------------------------------------
module gle_ctrl
    import gle_pkg::*;
#(
    parameter int DICT_SLOTS    = DICT_SLOTS_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [3:0]   code_size,
    input  logic [12:0]  dict_limit,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   pix_in,
    input  logic         last_in,
    output logic         code_valid,
    input  logic         code_ready,
    output gle_code_t    code_req,
    input  logic         pk_busy,
    output logic                          ram_we,
    output logic [$clog2(DICT_SLOTS)-1:0] ram_addr,
    output logic [ENTRY_W-1:0]            ram_wdata,
    input  logic [ENTRY_W-1:0]            ram_rdata
);
    localparam int AW = $clog2(DICT_SLOTS);
    localparam logic [12:0] LIM_MAX = 13'(1 << MAX_CODE_BITS);

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_PROBE = 4'd2;
    localparam logic [3:0] ST_CHECK = 4'd3;
    localparam logic [3:0] ST_C0    = 4'd4;
    localparam logic [3:0] ST_C1    = 4'd5;
    localparam logic [3:0] ST_C2    = 4'd6;
    localparam logic [3:0] ST_L0    = 4'd7;
    localparam logic [3:0] ST_L1    = 4'd8;
    localparam logic [3:0] ST_DRAIN = 4'd9;

    logic [3:0]  st_reg, st_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW:0]   tries_reg, tries_next;
    logic [11:0] prefix_reg, prefix_next;
    logic [12:0] ncode_reg, ncode_next;
    logic [3:0]  width_reg, width_next;
    logic        started_reg, started_next;
    logic [7:0]  pix_reg, pix_next;
    logic        last_reg, last_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic        slot_ok_reg, slot_ok_next;
    logic [KEY_W-1:0] key;
    logic [3:0]  m;
    logic [8:0]  clear;
    logic [12:0] lim;
    logic [7:0]  pix_m;

    always_comb begin
        m = (code_size < 4'd2) ? 4'd2 : (code_size > 4'd8) ? 4'd8 : code_size;
        clear = 9'd1 << m;
        lim = (dict_limit > LIM_MAX) ? LIM_MAX : dict_limit;
        pix_m = 8'(pix_in & 8'(clear - 9'd1));
        key = {prefix_reg, pix_reg};
    end

    assign s_axis_tready = (st_reg == ST_IDLE);

    always_comb begin
        st_next = st_reg;
        pos_next = pos_reg;
        tries_next = tries_reg;
        prefix_next = prefix_reg;
        ncode_next = ncode_reg;
        width_next = width_reg;
        started_next = started_reg;
        pix_next = pix_reg;
        last_next = last_reg;
        slot_next = slot_reg;
        slot_ok_next = slot_ok_reg;
        ram_we = 1'b0;
        ram_addr = pos_reg;
        ram_wdata = '0;
        code_valid = 1'b0;
        code_req = '{code: prefix_reg, width: width_reg, flush: 1'b0};
        unique case (st_reg)
            ST_CLR: begin
                ram_we = 1'b1;
                pos_next = pos_reg + AW'(1);
                if (pos_reg == AW'(DICT_SLOTS - 1)) begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    pix_next = pix_m;
                    last_next = last_in;
                    if (!started_reg) begin
                        width_next = m + 4'd1;
                        ncode_next = 13'(clear) + 13'd2;
                        prefix_next = 12'(pix_m);
                        started_next = 1'b1;
                        st_next = ST_C2;
                    end else begin
                        pos_next = AW'(gle_hash({prefix_reg, pix_m}));
                        tries_next = '0;
                        st_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                st_next = ST_CHECK;
            end
            ST_CHECK: begin
                ram_addr = pos_reg;
                if (ram_rdata[CODE_W-1:0] == 12'd0) begin
                    slot_next = pos_reg;
                    slot_ok_next = 1'b1;
                    st_next = ST_C0;
                end else if (ram_rdata[ENTRY_W-1:CODE_W] == key) begin
                    prefix_next = ram_rdata[CODE_W-1:0];
                    st_next = last_reg ? ST_L0 : ST_IDLE;
                end else if (tries_reg == (AW+1)'(DICT_SLOTS - 1)) begin
                    slot_ok_next = 1'b0;
                    st_next = ST_C0;
                end else begin
                    pos_next = (pos_reg == AW'(DICT_SLOTS - 1)) ? '0 : pos_reg + AW'(1);
                    tries_next = tries_reg + (AW+1)'(1);
                    st_next = ST_PROBE;
                end
            end
            ST_C0: begin
                code_valid = 1'b1;
                if (code_ready) begin
                    prefix_next = 12'(pix_reg);
                    if (ncode_reg >= lim) begin
                        st_next = ST_C1;
                    end else begin
                        if (ncode_reg >= (13'd1 << width_reg)) begin
                            width_next = width_reg + 4'd1;
                        end
                        ram_we = slot_ok_reg;
                        ram_addr = slot_reg;
                        ram_wdata = {key, ncode_reg[CODE_W-1:0]};
                        ncode_next = ncode_reg + 13'd1;
                        st_next = last_reg ? ST_L0 : ST_IDLE;
                    end
                end
            end
            ST_C1: begin
                code_valid = 1'b1;
                code_req.code = 12'(clear);
                if (code_ready) begin
                    width_next = m + 4'd1;
                    ncode_next = 13'(clear) + 13'd2;
                    pos_next = '0;
                    st_next = last_reg ? ST_L0 : ST_CLR;
                    if (!last_reg) st_next = ST_CLR;
                end
            end
            ST_C2: begin
                code_valid = 1'b1;
                code_req.code = 12'(clear);
                if (code_ready) st_next = last_reg ? ST_L0 : ST_IDLE;
            end
            ST_L0: begin
                code_valid = 1'b1;
                if (code_ready) st_next = ST_L1;
            end
            ST_L1: begin
                code_valid = 1'b1;
                code_req.code = 12'(clear) + 12'd1;
                code_req.flush = 1'b1;
                if (code_ready) begin
                    prefix_next = '0;
                    started_next = 1'b0;
                    st_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pk_busy) begin
                    pos_next = '0;
                    st_next = ST_CLR;
                end
            end
            default: st_next = ST_CLR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLR;
            pos_reg <= '0;
            started_reg <= 1'b0;
            prefix_reg <= '0;
            width_reg <= 4'd9;
            ncode_reg <= 13'd258;
        end else begin
            st_reg <= st_next;
            pos_reg <= pos_next;
            started_reg <= started_next;
            prefix_reg <= prefix_next;
            width_reg <= width_next;
            ncode_reg <= ncode_next;
        end
        tries_reg <= tries_next;
        pix_reg <= pix_next;
        last_reg <= last_next;
        slot_reg <= slot_next;
        slot_ok_reg <= slot_ok_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> !code_valid)
        else $error("input taken while emitting");
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && st_reg != ST_CLR |-> ram_wdata[CODE_W-1:0] != 12'd0)
        else $error("empty code written to dictionary");
    assert property (@(posedge aclk) disable iff (!aresetn)
        width_reg <= 4'(MAX_CODE_BITS) || !started_reg)
        else $error("code width too large");
endmodule

### sv/gif_lzw_encoder_core.sv
// ----------------------------------------------------------------------------
// gif_lzw_encoder_core
// GIF-style LZW encoder: pixel indexes in, LSB-first packed code bytes out.
// ----------------------------------------------------------------------------
// s_axis carries one pixel request: tdata = pixel_index, tlast = last pixel.
// m_axis carries one packed byte: tdata = out_byte, tlast = final padded byte.
// cfg writes: index 0 code size, index 1 dict_limit; write while idle.
// Each pixel after the first of an image takes a hashed dictionary probe in
// the single-port RAM, with one more probe per collision; a miss also sends
// a code to the bit packer. The first pixel of an image sends a clear code.
// A clear code sent on a full dictionary, or the end of an image, starts a
// sweep that writes every dictionary slot empty; after reset the same sweep
// runs and s_axis_tready stays low until it ends.
// Bytes leave through a one-entry output register; when the receiver stalls
// the packer holds up to 19 bits, then the sequencer and s_axis stall.
// ----------------------------------------------------------------------------
module gif_lzw_encoder_core
    import gle_pkg::*;
#(
    parameter int DICT_SLOTS    = DICT_SLOTS_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_index
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    localparam int AW = $clog2(DICT_SLOTS);

    logic [3:0]  mcs_reg;
    logic [12:0] lim_reg;
    logic        code_valid, code_ready, pk_busy;
    gle_code_t   code_req;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcs_reg <= 4'd8;
            lim_reg <= 13'd4096;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CODE_SIZE:  mcs_reg <= cfg_data[3:0];
                REG_DICT_LIMIT: lim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    gle_ctrl #(.DICT_SLOTS(DICT_SLOTS), .MAX_CODE_BITS(MAX_CODE_BITS)) u_ctrl (
        .aclk, .aresetn,
        .code_size(mcs_reg), .dict_limit(lim_reg),
        .s_axis_tvalid, .s_axis_tready,
        .pix_in(s_axis_tdata), .last_in(s_axis_tlast),
        .code_valid, .code_ready, .code_req, .pk_busy,
        .ram_we, .ram_addr, .ram_wdata, .ram_rdata
    );

    gle_ram #(.WIDTH(ENTRY_W), .DEPTH(DICT_SLOTS)) u_dict (
        .aclk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    gle_packer u_pack (
        .aclk, .aresetn, .code_valid, .code_ready, .code_req, .busy(pk_busy),
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser(m_axis_tlast)
    );
endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream test of the LZW encoder core. Images of pixel requests go in through
// a queue-fed driver. Each accepted pixel updates a behavioral LZW packer
// that produces the expected code bytes. The monitor checks every output
// byte in order. Phases change the code size and the dictionary limit while
// the core is idle, and vary the sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;
    import gle_pkg::*;

    localparam int NSLOTS    = 8192;
    localparam int MAXBITS   = 12;
    localparam int SWEEP_GAP = NSLOTS + 400;
    localparam int CYC_LIMIT = 10000000;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [7:0] pix;
        logic       last;
    } pix_req_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } code_byte_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_CODE_SIZE;
    logic [12:0] cfg_data = 0;

    gif_lzw_encoder_core dut (.*);

    always #5 aclk = ~aclk;

    pix_req_t   pix_q[$];
    code_byte_t byte_q[$];
    code_byte_t step_q[$];
    idle_mode_t idle_mode = IDLE_NONE;
    int         errors = 0;
    int         cycles = 0;
    logic       pix_taken = 0;
    bit         hold_go = 0;
    bit         hold_done = 0;
    int         hold_cnt = 0;

    // behavioral encoder state
    bit [31:0] lzw_dict [NSLOTS];
    int        cur_prefix, free_code, cur_width, acc_bits, acc_cnt;
    bit        in_image;
    int        reg_min, reg_limit;

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    endtask

    function automatic int eff_min();
        return reg_min < 2 ? 2 : (reg_min > 8 ? 8 : reg_min);
    endfunction

    function automatic int eff_limit();
        return reg_limit > (1 << MAXBITS) ? (1 << MAXBITS) : reg_limit;
    endfunction

    task automatic restart_dict();
        foreach (lzw_dict[i]) lzw_dict[i] = 0;
        cur_width = eff_min() + 1;
        free_code = (1 << eff_min()) + 2;
    endtask

    task automatic pack_code(input int code, input int width);
        longint acc;
        code_byte_t b;
        acc = longint'(acc_bits) | (longint'(code & ((1 << width) - 1)) << acc_cnt);
        acc_cnt += width;
        while (acc_cnt >= 8) begin
            b.data = acc[7:0];
            b.last = 0;
            step_q.push_back(b);
            acc = acc >> 8;
            acc_cnt -= 8;
        end
        acc_bits = int'(acc & 'hFF);
    endtask

    task automatic find_string(input int key, output bit hit, output int code,
                               output int slot);
        bit [31:0] prod;
        int pos;
        bit [31:0] e;
        hit = 0;
        slot = -1;
        code = 0;
        prod = 32'(key) * 32'd2654435761;
        pos = int'(prod >> 7) % NSLOTS;
        for (int n = 0; n < NSLOTS; n++) begin
            e = lzw_dict[pos];
            if (e[11:0] == 0) begin
                slot = pos;
                return;
            end
            if (int'(e >> 12) == key) begin
                hit = 1;
                code = int'(e[11:0]);
                return;
            end
            pos = (pos + 1) % NSLOTS;
        end
    endtask

    task automatic encode_pixel(input logic [7:0] pix_in, input logic last);
        int clr, pix, key, code, slot;
        bit hit;
        code_byte_t b;
        clr = 1 << eff_min();
        pix = int'(pix_in) & (clr - 1);
        step_q.delete();
        if (!in_image) begin
            restart_dict();
            acc_bits = 0;
            acc_cnt = 0;
            pack_code(clr, cur_width);
            cur_prefix = pix;
            in_image = 1;
        end else begin
            key = ((cur_prefix & 'hFFF) << 8) | pix;
            find_string(key, hit, code, slot);
            if (hit) begin
                cur_prefix = code;
            end else begin
                pack_code(cur_prefix, cur_width);
                cur_prefix = pix;
                if (free_code >= eff_limit()) begin
                    pack_code(clr, cur_width);
                    restart_dict();
                end else begin
                    if (free_code >= (1 << cur_width)) cur_width++;
                    if (slot >= 0) lzw_dict[slot] = (key << 12) | (free_code & 'hFFF);
                    free_code++;
                end
            end
        end
        if (last) begin
            pack_code(cur_prefix, cur_width);
            pack_code(clr + 1, cur_width);
            if (acc_cnt > 0) begin
                b.data = acc_bits[7:0];
                b.last = 0;
                step_q.push_back(b);
            end
            acc_bits = 0;
            acc_cnt = 0;
            cur_prefix = 0;
            in_image = 0;
            restart_dict();
        end
        while (step_q.size() > 7) void'(step_q.pop_back());
        if (last && step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
        foreach (step_q[i]) byte_q.push_back(step_q[i]);
    endtask

    // accepted requests: predict, check, config
    always @(posedge aclk) begin
        code_byte_t want;
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("[gif_lzw_encoder_core] ERROR");
            $finish;
        end
        pix_taken <= aresetn && s_axis_tvalid && s_axis_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_CODE_SIZE) reg_min = int'(cfg_data[3:0]);
                else reg_limit = int'(cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) encode_pixel(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (byte_q.size() == 0) begin
                    report("unexpected byte", int'(m_axis_tdata), 0);
                end else begin
                    want = byte_q.pop_front();
                    if (m_axis_tdata !== want.data)
                        report("out_byte", int'(m_axis_tdata), int'(want.data));
                    if (m_axis_tlast !== want.last)
                        report("last_byte", int'(m_axis_tlast), int'(want.last));
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt <= 0;
        end else if (hold_go && !hold_done && hold_cnt == 0) begin
            hold_cnt <= 3000;
            hold_done <= 1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // pixel driver
    always @(negedge aclk) begin
        pix_req_t r;
        bit idle;
        idle = (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 45) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 9);
        if (!aresetn) begin
            s_axis_tvalid <= 0;
        end else if (!s_axis_tvalid || pix_taken) begin
            if (pix_q.size() != 0 && !idle) begin
                r = pix_q.pop_front();
                s_axis_tvalid <= 1;
                s_axis_tdata <= r.pix;
                s_axis_tlast <= r.last;
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // byte receiver
    always @(negedge aclk) begin
        bit stall;
        stall = (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 45) ||
                (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 9);
        m_axis_tready <= aresetn && hold_cnt == 0 && !stall;
    end

    task automatic write_reg(input logic [0:0] idx, input int value);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= 13'(value);
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic wait_drained();
        while (pix_q.size() != 0 || s_axis_tvalid || byte_q.size() != 0) @(posedge aclk);
        repeat (SWEEP_GAP) @(posedge aclk);
    endtask

    task automatic push_pix(input int pix, input bit last);
        pix_req_t r;
        r.pix = 8'(pix);
        r.last = last;
        pix_q.push_back(r);
    endtask

    // one well-formed image; mostly a small alphabet so strings repeat
    task automatic add_image(input int len);
        int p;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 255);
            else p = $urandom_range(0, 3) + ($urandom_range(0, 3) == 0 ? 8 : 0);
            push_pix(p, i == len - 1);
        end
    endtask

    task automatic run_phase(input int msize, input int limit, input int nitems,
                             input idle_mode_t mode, input bit pressure);
        int left, len;
        write_reg(REG_CODE_SIZE, msize);
        write_reg(REG_DICT_LIMIT, limit);
        idle_mode = mode;
        hold_go = pressure;
        left = nitems;
        while (left > 0) begin
            if ($urandom_range(0, 7) == 0) begin
                // short image: lone last pixel
                len = 1;
            end else begin
                len = $urandom_range(8, 60);
            end
            if (len > left) len = left;
            add_image(len);
            left -= len;
        end
        wait_drained();
    endtask

    initial begin
        reg_min = 8;
        reg_limit = 4096;
        in_image = 0;
        cur_prefix = 0;
        acc_bits = 0;
        acc_cnt = 0;
        restart_dict();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: extremes, repeats, single-pixel image, out-of-range index
        push_pix(0, 0);
        push_pix(255, 0);
        push_pix(255, 0);
        push_pix(255, 0);
        push_pix(255, 0);
        push_pix(128, 0);
        push_pix(0, 1);
        push_pix(128, 1);
        push_pix(255, 1);
        wait_drained();
        write_reg(REG_CODE_SIZE, 2);
        write_reg(REG_DICT_LIMIT, 4);
        push_pix(255, 0);
        push_pix(1, 0);
        push_pix(2, 0);
        push_pix(1, 0);
        push_pix(2, 1);
        wait_drained();
        write_reg(REG_CODE_SIZE, 15);
        write_reg(REG_DICT_LIMIT, 8191);
        push_pix(255, 0);
        push_pix(0, 0);
        push_pix(255, 0);
        push_pix(0, 0);
        push_pix(255, 0);
        push_pix(0, 1);
        wait_drained();

        run_phase(2, 4096, 70, IDLE_SEND, 0);
        run_phase(8, 4096, 70, IDLE_RECV, 0);
        run_phase(4, 12, 30, IDLE_BOTH, 0);
        run_phase(15, 8191, 90, IDLE_NONE, 1);
        run_phase(0, 64, 120, IDLE_SEND, 0);
        run_phase(7, 4, 20, IDLE_BOTH, 0);
        run_phase(3, 8191, 70, IDLE_RECV, 0);

        repeat (200) @(posedge aclk);
        if (errors == 0 && byte_q.size() == 0) begin
            $display("[gif_lzw_encoder_core] OK");
        end else begin
            $display("[gif_lzw_encoder_core] ERROR");
        end
        $finish;
    end

endmodule
